[sv/ptfr_pkg.sv]
// ----------------------------------------------------------------------------
// ptfr_pkg: shared constants for the preamble/trailer frame receiver
// Header and trailer characters, phase codes, status codes, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptfr_pkg;

    // Depth of the external frame buffer; the effective capacity never exceeds it
    localparam int BUF_DEPTH = 128;
    localparam logic [7:0] CAP_LIMIT = (BUF_DEPTH > 255) ? 8'd255 : 8'(BUF_DEPTH);

    localparam logic [7:0] MIN_CAPACITY = 8'd16;
    localparam logic [8:0] TRAILER_ROOM = 9'd4;

    // Header and trailer characters
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Receiver phases
    localparam logic [2:0] PH_H1  = 3'd0;
    localparam logic [2:0] PH_H2  = 3'd1;
    localparam logic [2:0] PH_H3  = 3'd2;
    localparam logic [2:0] PH_H4  = 3'd3;
    localparam logic [2:0] PH_PAY = 3'd4;
    localparam logic [2:0] PH_E1  = 3'd5;
    localparam logic [2:0] PH_E2  = 3'd6;
    localparam logic [2:0] PH_E3  = 3'd7;

    // Frame end status
    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_TIMEOUT  = 2'd1;
    localparam status_t ST_OVERFLOW = 2'd2;

    // Configuration register indexes
    localparam logic REG_IDLE_LIMIT     = 1'b0;
    localparam logic REG_FRAME_CAPACITY = 1'b1;

    // Expected header byte for header phases 1..3
    function automatic logic [7:0] hdr_char(input logic [1:0] ph);
        logic [7:0] c;
        unique case (ph)
            2'd0:    c = CH_A;
            2'd1:    c = CH_L;
            2'd2:    c = CH_T;
            default: c = CH_O;
        endcase
        return c;
    endfunction

endpackage

[sv/preamble_trailer_frame_receiver.sv]
// ----------------------------------------------------------------------------
// preamble_trailer_frame_receiver
// Byte-stream deframer: sync word hunt, buffer write strobes, end marker,
// idle timeout and overflow detection.
// ----------------------------------------------------------------------------
// Each request on the s_ side is either a received byte or one idle tick and
// yields exactly one result request on the m_ side, registered on accept.
// The block hunts for the four-byte sync word (restarting on every 'A'),
// emits a write strobe with index and byte for every header, payload and
// trailer byte, and ends the frame on CR LF CR LF with status complete.
// An idle tick counts the idle limit down (reloaded on the first header byte,
// after every frame end and on a write of idle_limit); reaching zero ends the
// frame with status timeout. Less than four bytes of room left in the payload
// or trailer ends it with status overflow and drops that request. An idle
// limit of 0 waits forever; a frame capacity below 16 disables the block.
// Rate: one request per cycle while results are drained. The whole per-item update
// is one pass of logic from the state registers into the result register.
// s_tready is low only while a result waits for m_tready; a result drained
// at an edge makes room for a new request at that same edge.
`timescale 1ns / 1ps

module preamble_trailer_frame_receiver
    import ptfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command (0 byte, 1 idle tick)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [6:0] store_index, [14:7] store_byte,
                                   // [16:15] frame_status, [24:17] frame_length,
                                   // [31:25] zero
    output logic        m_tuser,   // [0] store_write
    output logic        m_tlast    // frame_end
);

    // configuration
    logic [15:0] idle_limit_reg;
    logic [7:0]  frame_capacity_reg;

    // receiver state
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [15:0] countdown_reg, countdown_next;

    // result register
    logic        m_valid_reg;
    logic        wr_reg, wr_next;
    logic [6:0]  idx_reg, idx_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    status_t     status_reg, status_next;
    logic [7:0]  length_reg, length_next;

    logic        s_fire;
    logic [7:0]  cap_eff;
    logic [15:0] count_dec;
    logic [7:0]  b;

    // Accept while the result register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign b        = s_tdata;

    assign cap_eff   = (frame_capacity_reg > CAP_LIMIT) ? CAP_LIMIT : frame_capacity_reg;
    assign count_dec = (countdown_reg != 16'd0) ? countdown_reg - 16'd1 : 16'd0;

    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        countdown_next  = countdown_reg;
        wr_next         = 1'b0;
        idx_next        = '0;
        byte_next       = '0;
        end_next        = 1'b0;
        status_next     = ST_OK;
        length_next     = '0;

        if (frame_capacity_reg < MIN_CAPACITY) begin
            // disabled: hold state, empty result
        end else if (phase_reg >= PH_PAY &&
                     ({1'b0, byte_count_reg} + TRAILER_ROOM) > {1'b0, cap_eff}) begin
            // no room for a trailer: drop the request and close the frame
            end_next        = 1'b1;
            status_next     = ST_OVERFLOW;
            length_next     = byte_count_reg;
            phase_next      = PH_H1;
            byte_count_next = '0;
            countdown_next  = idle_limit_reg;
        end else if (s_tuser == CMD_TICK) begin
            if (idle_limit_reg != 16'd0) begin
                if (count_dec == 16'd0) begin
                    end_next        = 1'b1;
                    status_next     = ST_TIMEOUT;
                    length_next     = byte_count_reg;
                    phase_next      = PH_H1;
                    byte_count_next = '0;
                    countdown_next  = idle_limit_reg;
                end else begin
                    countdown_next  = count_dec;
                end
            end
        end else if (phase_reg <= PH_H4) begin
            if (phase_reg == PH_H1) begin
                if (b == CH_A) begin
                    wr_next         = 1'b1;
                    byte_next       = b;
                    byte_count_next = 8'd1;
                    countdown_next  = idle_limit_reg;
                    phase_next      = PH_H2;
                end
            end else if (b == hdr_char(phase_reg[1:0])) begin
                wr_next         = 1'b1;
                idx_next        = {5'd0, phase_reg[1:0]};
                byte_next       = b;
                byte_count_next = {5'd0, phase_reg} + 8'd1;
                phase_next      = phase_reg + 3'd1;
            end else if (b == CH_A) begin
                // restart the hunt on a fresh first header byte
                wr_next         = 1'b1;
                byte_next       = b;
                byte_count_next = 8'd1;
                phase_next      = PH_H2;
            end else begin
                byte_count_next = '0;
                phase_next      = PH_H1;
            end
        end else begin
            wr_next         = 1'b1;
            idx_next        = byte_count_reg[6:0];
            byte_next       = b;
            byte_count_next = byte_count_reg + 8'd1;
            unique case (phase_reg)
                PH_PAY: begin
                    if (b == CH_CR) phase_next = PH_E1;
                end
                PH_E1: begin
                    if (b == CH_LF)      phase_next = PH_E2;
                    else if (b != CH_CR) phase_next = PH_PAY;
                end
                PH_E2: begin
                    phase_next = (b == CH_CR) ? PH_E3 : PH_PAY;
                end
                default: begin
                    if (b == CH_LF) begin
                        // end marker complete: length counts this byte
                        end_next        = 1'b1;
                        status_next     = ST_OK;
                        length_next     = byte_count_reg + 8'd1;
                        phase_next      = PH_H1;
                        byte_count_next = '0;
                        countdown_next  = idle_limit_reg;
                    end else if (b == CH_CR) begin
                        phase_next = PH_E1;
                    end else begin
                        phase_next = PH_PAY;
                    end
                end
            endcase
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg     <= 16'd0;
            frame_capacity_reg <= 8'd128;
            phase_reg          <= PH_H1;
            byte_count_reg     <= '0;
            countdown_reg      <= 16'd0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IDLE_LIMIT: begin
                        idle_limit_reg <= cfg_wdata;
                        countdown_reg  <= cfg_wdata;
                    end
                    REG_FRAME_CAPACITY: begin
                        frame_capacity_reg <= cfg_wdata[7:0];
                    end
                    default: ;
                endcase
            end else if (s_fire) begin
                countdown_reg <= countdown_next;
            end
            if (s_fire) begin
                phase_reg      <= phase_next;
                byte_count_reg <= byte_count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            wr_reg     <= wr_next;
            idx_reg    <= idx_next;
            byte_reg   <= byte_next;
            end_reg    <= end_next;
            status_reg <= status_next;
            length_reg <= length_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = wr_reg;
    assign m_tlast  = end_reg;
    assign m_tdata  = {7'd0, length_reg, status_reg, byte_reg, idx_reg};

endmodule

[sv/ptfr_checker.sv]
// ----------------------------------------------------------------------------
// ptfr_checker: port-level checks for the frame receiver
// Watches the result stream for field consistency and request flow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptfr_checker
    import ptfr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // An accepted request always produces a result in the next cycle
    a_accept_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted request produced no result");

    // Without a frame end, status and length read zero
    a_no_end_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[24:15] == 10'd0))
        else $error("status or length set without frame end");

    // Without a write strobe, index and byte read zero
    a_no_write_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[14:0] == 15'd0))
        else $error("index or byte set without write strobe");

    // A frame end carries a defined status and a length within the buffer
    a_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            ((m_tdata[16:15] == ST_OK || m_tdata[16:15] == ST_TIMEOUT ||
              m_tdata[16:15] == ST_OVERFLOW) && m_tdata[24:17] <= 8'd128))
        else $error("bad frame end status or length");

    // A stalled result stays presented
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

endmodule

bind preamble_trailer_frame_receiver ptfr_checker u_ptfr_checker (.*);
